[hdl/uart_register_fifo_front_top_macros.svh]
// Assertion macros for the UART register front.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef UART_REGISTER_FIFO_FRONT_TOP_MACROS_SVH
`define UART_REGISTER_FIFO_FRONT_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define URFF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("urff check failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define URFF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("urff check failed: next-cycle implication");

`endif

[hdl/urff_pkg.sv]
// Shared types and register map for the UART register front.
// No dependencies; imported by the top level.
`default_nettype none
package urff_pkg;

   typedef enum logic [1:0] {
      OP_READ     = 2'd0,
      OP_WRITE    = 2'd1,
      OP_RX_BYTE  = 2'd2,
      OP_TX_READY = 2'd3
   } op_type;

   localparam logic [7:0] REG_TXLEVEL = 8'd0;
   localparam logic [7:0] REG_RXLEVEL = 8'd4;
   localparam logic [7:0] REG_RXCHAR  = 8'd8;
   localparam logic [7:0] REG_TXCHAR  = 8'd12;
   localparam logic [7:0] REG_CLKDIV  = 8'd16;

   typedef struct packed {
      op_type      op;
      logic [7:0]  addr;
      logic [31:0] wdata;
      logic [7:0]  rx_byte;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] rdata;
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic        tx_irq;
      logic        rx_irq;
      logic        tx_overflow;
      logic        rx_overflow;
   } rsp_payload_type;

endpackage
`default_nettype wire

[hdl/urff_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none
module urff_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

[hdl/uart_register_fifo_front_top.sv]
// Top level of the UART register front: bus decode, TX and RX byte FIFOs.
// Depends on urff_pkg, urff_ram and uart_register_fifo_front_top_macros.svh.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | urff_pkg::req_payload_type
//   rsp     | out       | rsp_valid/rsp_stall  | urff_pkg::rsp_payload_type
//
// One item per cycle sustained while rsp_stall is low; each item passes through the input
// register and then the result register. Each FIFO RAM is read at the next head, so
// its registered read data matches the current head and its read port adds no register.
// Synchronous active-high reset empties both FIFOs and drops any item in flight.
// A stalled result holds; one more item is taken into the input register behind it.
// Reset needs no clearing pass: FIFO contents count only below the fill level.
`default_nettype none
module uart_register_fifo_front_top #(
   parameter int FIFO_DEPTH = 32
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire urff_pkg::req_payload_type req_payload,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output urff_pkg::rsp_payload_type      rsp_payload
);
   import urff_pkg::*;
   `include "uart_register_fifo_front_top_macros.svh"

   localparam int AW = $clog2(FIFO_DEPTH);
   localparam int CW = $clog2(FIFO_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_CNT = CW'(FIFO_DEPTH);
   localparam logic [AW-1:0] LAST_IDX  = AW'(FIFO_DEPTH - 1);

   function automatic logic [AW-1:0] wrap_sum(input logic [AW-1:0] head,
                                             input logic [CW-1:0] count);
      logic [CW:0] s;
      s = (CW+1)'(head) + (CW+1)'(count);
      if (s >= (CW+1)'(FIFO_DEPTH)) begin
         s = s - (CW+1)'(FIFO_DEPTH);
      end
      return AW'(s);
   endfunction

   function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] head);
      return (head == LAST_IDX) ? '0 : AW'(head + 1'b1);
   endfunction

   logic            s1_valid_ff, s1_valid_in;
   req_payload_type s1_ff, s1_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;

   logic [CW-1:0] tx_count_ff, tx_count_in, tx_count_step;
   logic [AW-1:0] tx_head_ff, tx_head_in, tx_head_step;
   logic [CW-1:0] rx_count_ff, rx_count_in, rx_count_step;
   logic [AW-1:0] rx_head_ff, rx_head_in, rx_head_step;

   logic       tx_byp_ff, tx_byp_in, rx_byp_ff, rx_byp_in;
   logic [7:0] tx_byp_data_ff, rx_byp_data_ff;

   logic          advance, accept;
   logic          tx_push, tx_we, rx_push, rx_we;
   logic [AW-1:0] tx_waddr, rx_waddr;
   logic [7:0]    tx_wdata, rx_wdata, tx_ram_rdata, rx_ram_rdata, tx_rd, rx_rd;
   rsp_payload_type result;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign tx_rd = tx_byp_ff ? tx_byp_data_ff : tx_ram_rdata;
   assign rx_rd = rx_byp_ff ? rx_byp_data_ff : rx_ram_rdata;

   always_comb begin
      result        = '0;
      tx_count_step = tx_count_ff;
      tx_head_step  = tx_head_ff;
      rx_count_step = rx_count_ff;
      rx_head_step  = rx_head_ff;
      tx_push       = 1'b0;
      rx_push       = 1'b0;
      tx_wdata      = s1_ff.wdata[7:0];
      rx_wdata      = s1_ff.rx_byte;
      tx_waddr      = wrap_sum(tx_head_ff, tx_count_ff);
      rx_waddr      = wrap_sum(rx_head_ff, rx_count_ff);
      case (s1_ff.op)
         OP_READ: begin
            if (s1_ff.addr == REG_TXLEVEL) begin
               result.rdata = {8'(DEPTH_CNT - tx_count_ff), 24'h000000};
            end else if (s1_ff.addr == REG_RXLEVEL) begin
               result.rdata = {8'(rx_count_ff), 24'h000000};
            end else if (s1_ff.addr == REG_RXCHAR) begin
               if (rx_count_ff != '0) begin
                  result.rdata  = {24'h000000, rx_rd};
                  rx_head_step  = next_idx(rx_head_ff);
                  rx_count_step = rx_count_ff - 1'b1;
               end
            end
         end
         OP_WRITE: begin
            if (s1_ff.addr == REG_CLKDIV) begin
               result.tx_overflow = 1'b0;
            end else if (s1_ff.addr == REG_TXCHAR) begin
               if (tx_count_ff == DEPTH_CNT) begin
                  result.tx_overflow = 1'b1;
               end else begin
                  tx_push       = 1'b1;
                  tx_count_step = tx_count_ff + 1'b1;
               end
            end
         end
         OP_RX_BYTE: begin
            if (rx_count_ff == DEPTH_CNT) begin
               result.rx_overflow = 1'b1;
            end else begin
               rx_push       = 1'b1;
               rx_count_step = rx_count_ff + 1'b1;
            end
         end
         OP_TX_READY: begin
            if (tx_count_ff != '0) begin
               result.tx_valid = 1'b1;
               result.tx_byte  = tx_rd;
               tx_head_step    = next_idx(tx_head_ff);
               tx_count_step   = tx_count_ff - 1'b1;
            end
         end
         default: begin
            result = '0;
         end
      endcase
      result.tx_irq = (tx_count_step != DEPTH_CNT);
      result.rx_irq = (rx_count_step != '0);

      tx_we       = advance && tx_push;
      rx_we       = advance && rx_push;
      tx_count_in = advance ? tx_count_step : tx_count_ff;
      tx_head_in  = advance ? tx_head_step : tx_head_ff;
      rx_count_in = advance ? rx_count_step : rx_count_ff;
      rx_head_in  = advance ? rx_head_step : rx_head_ff;
      tx_byp_in   = tx_we && (tx_waddr == tx_head_in);
      rx_byp_in   = rx_we && (rx_waddr == rx_head_in);

      s1_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      s1_in        = accept ? req_payload : s1_ff;
      rsp_valid_in = advance ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
      rsp_in       = advance ? result : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tx_count_ff  <= '0;
         tx_head_ff   <= '0;
         rx_count_ff  <= '0;
         rx_head_ff   <= '0;
         tx_byp_ff    <= 1'b0;
         rx_byp_ff    <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         tx_count_ff  <= tx_count_in;
         tx_head_ff   <= tx_head_in;
         rx_count_ff  <= rx_count_in;
         rx_head_ff   <= rx_head_in;
         tx_byp_ff    <= tx_byp_in;
         rx_byp_ff    <= rx_byp_in;
      end
      s1_ff          <= s1_in;
      rsp_ff         <= rsp_in;
      tx_byp_data_ff <= tx_wdata;
      rx_byp_data_ff <= rx_wdata;
   end

   urff_ram #(
      .WIDTH(8),
      .DEPTH(FIFO_DEPTH)
   ) u_tx_ram (
      .clock(clock),
      .we   (tx_we),
      .waddr(tx_waddr),
      .wdata(tx_wdata),
      .raddr(tx_head_in),
      .rdata(tx_ram_rdata)
   );

   urff_ram #(
      .WIDTH(8),
      .DEPTH(FIFO_DEPTH)
   ) u_rx_ram (
      .clock(clock),
      .we   (rx_we),
      .waddr(rx_waddr),
      .wdata(rx_wdata),
      .raddr(rx_head_in),
      .rdata(rx_ram_rdata)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `URFF_ASSERT_NOW(a_tx_count_range, clock, reset, 1'b1, (tx_count_ff <= DEPTH_CNT))
   `URFF_ASSERT_NOW(a_rx_count_range, clock, reset, 1'b1, (rx_count_ff <= DEPTH_CNT))
   `URFF_ASSERT_NOW(a_tx_ovf_full, clock, reset, (rsp_valid && rsp_payload.tx_overflow), (!rsp_payload.tx_irq))
   `URFF_ASSERT_NOW(a_rx_ovf_nonempty, clock, reset, (rsp_valid && rsp_payload.rx_overflow), (rsp_payload.rx_irq))
   `URFF_ASSERT_NEXT(a_tx_pop_frees, clock, reset, (advance && result.tx_valid), (tx_count_ff != DEPTH_CNT))

endmodule
`default_nettype wire
